// ===== rtl/sm3_pkg.sv =====
package sm3_pkg;

  localparam int WordW = 32;
  localparam int DigestWords = 8;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;

  localparam logic [31:0] TLow = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t Iv [DigestWords] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/sm3_stream_if.sv =====
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_item;
  modport source (output valid, data_word, byte_count, last_item, input ready);
  modport sink (input valid, data_word, byte_count, last_item, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sm3_round.sv =====
module sm3_round (
  input  logic              clk,
  input  logic              rst,
  input  sm3_pkg::comp_ctl_t ctl_in,
  input  sm3_pkg::word_t    blk [16],
  input  sm3_pkg::word_t    chain_in [8],
  output sm3_pkg::word_t    chain_out [8],
  output logic              busy,
  output logic              done
);
  import sm3_pkg::*;

  word_t w [16];
  word_t r [8];
  logic [6:0] rnd;
  logic run;

  word_t wn, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
  logic lo;

  always_comb begin
    lo = (rnd < 7'd16);
    tj = rotl(lo ? TLow : THigh, rnd[4:0]);
    wn = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    a12 = rotl(r[0], 5'd12);
    ss1 = rotl(a12 + r[4] + tj, 5'd7);
    ss2 = ss1 ^ a12;
    if (lo) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (w[0] ^ w[4]);
    tt2 = gg + r[7] + ss1 + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rnd <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run <= 1'b1;
        rnd <= '0;
      end else if (run) begin
        rnd <= rnd + 7'd1;
        if (rnd == 7'(Rounds - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      w <= blk;
      r <= chain_in;
    end else if (run) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      r[3] <= r[2];
      r[2] <= rotl(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rotl(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= p0(tt2);
    end
  end

  always_comb for (int i = 0; i < 8; i++) chain_out[i] = r[i] ^ chain_in[i];
  assign busy = run;

  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("done while running");
  a_cnt: assert property (@(posedge clk) disable iff (rst) run |-> rnd < 7'd64)
    else $error("round overflow");
  a_start: assert property (@(posedge clk) disable iff (rst) ctl_in.start |=> run)
    else $error("start lost");
endmodule

// ===== rtl/sm3_hash_engine_unit.sv =====
// input not ready after the 16th word of a block while its 64 compression rounds run
// last word: padding words fill the final block or blocks, then one or two compressions run
//   before the first of the 8 digest words
// one 16-word block and one message at a time, no input taken during padding, compression or digest output
// reset: synchronous active high, chain to iv, length and word position to zero
module sm3_hash_engine_unit (
  input logic clk,
  input logic rst,
  sm3_in_if.sink   in_ch,
  sm3_out_if.source out_ch
);
  import sm3_pkg::*;

  typedef enum logic [4:0] {
    S_IN   = 5'b00001,
    S_PAD  = 5'b00010,
    S_COMP = 5'b00100,
    S_OUT  = 5'b01000,
    S_WAIT = 5'b10000
  } st_t;

  st_t st;
  word_t win [16];
  word_t chain [8];
  word_t chain_new [8];
  logic [3:0] pos;
  logic [63:0] blen;
  logic pad_pending;   // pad byte still owed (4-byte last word)
  logic finishing;
  logic lenset;
  logic [2:0] oidx;
  comp_ctl_t ctl;
  logic cbusy, cdone;

  sm3_round u_round (
    .clk(clk), .rst(rst), .ctl_in(ctl), .blk(win), .chain_in(chain),
    .chain_out(chain_new), .busy(cbusy), .done(cdone)
  );

  word_t in_w, pad_w;
  logic [2:0] cnt;
  logic acc;

  always_comb begin
    cnt = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
    unique case (cnt)
      3'd0: in_w = {PadByte, 24'h0};
      3'd1: in_w = {in_ch.data_word[31:24], PadByte, 16'h0};
      3'd2: in_w = {in_ch.data_word[31:16], PadByte, 8'h0};
      3'd3: in_w = {in_ch.data_word[31:8], PadByte};
      default: in_w = in_ch.data_word;
    endcase
    if (!in_ch.last_item) in_w = in_ch.data_word;
    if (pad_pending) pad_w = {PadByte, 24'h0};
    else if (pos == 4'd14) pad_w = blen[63:32];
    else if (pos == 4'd15 && lenset) pad_w = blen[31:0];
    else pad_w = '0;
    acc = in_ch.valid && in_ch.ready;
    ctl = '{start: 1'b0, busy: cbusy, done: cdone};
    ctl.start = (st == S_COMP);
  end

  assign in_ch.ready = (st == S_IN);
  assign out_ch.valid = (st == S_OUT);
  assign out_ch.digest_word = chain[oidx];
  assign out_ch.word_index = oidx;
  assign out_ch.last_word = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IN;
      pos <= '0;
      blen <= '0;
      pad_pending <= 1'b0;
      finishing <= 1'b0;
      oidx <= '0;
      chain <= Iv;
    end else begin
      unique case (st)
        S_IN: if (acc) begin
          win[pos] <= in_w;
          pos <= pos + 4'd1;
          if (!in_ch.last_item) begin
            blen <= blen + 64'd32;
            if (pos == 4'd15) st <= S_COMP;
          end else begin
            blen <= blen + {58'd0, cnt, 3'd0};
            finishing <= 1'b1;
            pad_pending <= (cnt == 3'd4);
            st <= (pos == 4'd15) ? S_COMP : S_PAD;
          end
        end
        S_PAD: begin
          win[pos] <= pad_w;
          pad_pending <= 1'b0;
          pos <= pos + 4'd1;
          if (pos == 4'd15) st <= S_COMP;
        end
        S_COMP: st <= S_WAIT;
        S_WAIT: if (cdone) begin
          chain <= chain_new;
          if (!finishing) st <= S_IN;
          else if (pad_pending || pos != 4'd0 || !lenset) st <= S_PAD;
          else begin
            st <= S_OUT;
            oidx <= '0;
          end
        end
        S_OUT: if (out_ch.ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            st <= S_IN;
            chain <= Iv;
            blen <= '0;
            pos <= '0;
            finishing <= 1'b0;
          end
        end
        default: st <= S_IN;
      endcase
    end
  end

  // length high word placed in slot 14 of the final block
  always_ff @(posedge clk) begin
    if (rst) lenset <= 1'b0;
    else if (st == S_OUT) lenset <= 1'b0;
    else if (st == S_PAD && pos == 4'd14 && !pad_pending) lenset <= 1'b1;
    else if (st == S_IN && acc && in_ch.last_item) lenset <= 1'b0;
  end

  a_ready: assert property (@(posedge clk) disable iff (rst) cbusy |-> !in_ch.ready)
    else $error("ready while busy");
  a_outv: assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> finishing)
    else $error("output without message end");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> in_ch.ready)
    else $error("no return to input");
endmodule
